### rtl/ccd_pkg.sv
package ccd_pkg;

  localparam int unsigned DEF_MAX_ENCODED = 300;
  localparam int unsigned DEF_MAX_DATA    = 64;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] BLOCK_FULL = 8'hFF;

  // Frame status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_LEN      = 3'd2;
  localparam logic [2:0] ST_CRC      = 3'd3;
  localparam logic [2:0] ST_MALFORM  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_OTHER    = 3'd6;
  localparam logic [2:0] ST_TOO_LONG = 3'd7;

  localparam logic [8:0] DEC_CNT_MAX = 9'd511;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_en;
    logic eval_en;
    logic clear;
    logic rd_en;
    logic idx_inc;
  } ccd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_delim;
    logic frame_empty;
    logic single;
    logic last_byte;
  } ccd_stat_t;

  // CRC-8, MSB first, no reflection, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/ccd_byte_if.sv
interface ccd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] serial_byte;

  modport source (output valid, output serial_byte, input ready);
  modport sink (input valid, input serial_byte, output ready);
endinterface

### rtl/ccd_result_if.sv
interface ccd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic [2:0] status;
  logic [7:0] command_code;
  logic       last;

  modport source (output valid, output data_byte, output data_valid, output status,
                  output command_code, output last, input ready);
  modport sink (input valid, input data_byte, input data_valid, input status,
                input command_code, input last, output ready);
endinterface

### rtl/ccd_ram.sv
module ccd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ccd_datapath.sv
module ccd_datapath #(
  parameter int unsigned MAX_ENCODED = ccd_pkg::DEF_MAX_ENCODED,
  parameter int unsigned MAX_DATA    = ccd_pkg::DEF_MAX_DATA
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic [7:0]        byte_i,
  input  ccd_pkg::ccd_cmd_t cmd_i,
  output ccd_pkg::ccd_stat_t stat_o,
  output logic [7:0]        data_byte_o,
  output logic              data_valid_o,
  output logic [2:0]        status_o,
  output logic [7:0]        command_code_o,
  output logic              last_o
);
  import ccd_pkg::*;

  localparam int unsigned AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  logic [7:0]    opcode_q;
  logic [8:0]    enc_cnt_q, enc_cnt_d;
  logic          ovf_q, ovf_d;
  logic [7:0]    block_left_q, block_left_d;
  logic          zero_pend_q, zero_pend_d;
  logic          malform_q, malform_d;
  logic [8:0]    dec_cnt_q, dec_cnt_d;
  logic [7:0]    crc_q, crc_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [7:0]    len_q, len_d;
  logic [2:0]    status_q, status_d;
  logic          emit_q;
  logic [AW-1:0] rd_idx_q;

  logic          take;
  logic [7:0]    take_byte;
  logic [8:0]    store_idx;
  logic          ram_we;
  logic [7:0]    ram_rdata;

  // Decoder update for one non-zero encoded byte.
  always_comb begin
    enc_cnt_d    = enc_cnt_q;
    ovf_d        = ovf_q;
    block_left_d = block_left_q;
    zero_pend_d  = zero_pend_q;
    malform_d    = malform_q;
    dec_cnt_d    = dec_cnt_q;
    crc_d        = crc_q;
    cmd_d        = cmd_q;
    len_d        = len_q;
    take         = 1'b0;
    take_byte    = 8'd0;
    ram_we       = 1'b0;
    store_idx    = dec_cnt_q - 9'd2;

    if (cmd_i.byte_en && !ovf_q) begin
      if (enc_cnt_q >= 9'(MAX_ENCODED)) begin
        ovf_d = 1'b1;
      end else begin
        enc_cnt_d = enc_cnt_q + 9'd1;
        if (block_left_q == 8'd0) begin
          // A pending zero only materializes once another code byte arrives.
          take         = zero_pend_q;
          take_byte    = 8'd0;
          block_left_d = byte_i - 8'd1;
          zero_pend_d  = (byte_i != BLOCK_FULL);
        end else begin
          take         = 1'b1;
          take_byte    = byte_i;
          block_left_d = block_left_q - 8'd1;
        end
      end
    end

    if (take) begin
      if (dec_cnt_q == DEC_CNT_MAX) begin
        malform_d = 1'b1;
      end else begin
        crc_d     = crc8_update(crc_q, take_byte);
        dec_cnt_d = dec_cnt_q + 9'd1;
        if (dec_cnt_q == 9'd0) begin
          cmd_d = take_byte;
        end else if (dec_cnt_q == 9'd1) begin
          len_d = take_byte;
        end else if (store_idx < 9'(MAX_DATA)) begin
          ram_we = 1'b1;
        end
      end
    end
  end

  // Status priority at the delimiter.
  always_comb begin
    if (ovf_q) begin
      status_d = ST_OVERFLOW;
    end else if (malform_q || block_left_q != 8'd0) begin
      status_d = ST_MALFORM;
    end else if (dec_cnt_q < 9'd3) begin
      status_d = ST_SHORT;
    end else if (dec_cnt_q != ({1'b0, len_q} + 9'd3)) begin
      status_d = ST_LEN;
    end else if (crc_q != 8'd0) begin
      status_d = ST_CRC;
    end else if ({1'b0, len_q} > 9'(MAX_DATA)) begin
      status_d = ST_TOO_LONG;
    end else if (cmd_q != opcode_q) begin
      status_d = ST_OTHER;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcode_q <= 8'd1;
    end else if (cfg_we_i) begin
      opcode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_cnt_q    <= '0;
      ovf_q        <= 1'b0;
      block_left_q <= '0;
      zero_pend_q  <= 1'b0;
      malform_q    <= 1'b0;
      dec_cnt_q    <= '0;
      crc_q        <= '0;
      cmd_q        <= '0;
      len_q        <= '0;
    end else if (cmd_i.clear) begin
      enc_cnt_q    <= '0;
      ovf_q        <= 1'b0;
      block_left_q <= '0;
      zero_pend_q  <= 1'b0;
      malform_q    <= 1'b0;
      dec_cnt_q    <= '0;
      crc_q        <= '0;
      cmd_q        <= '0;
      len_q        <= '0;
    end else begin
      enc_cnt_q    <= enc_cnt_d;
      ovf_q        <= ovf_d;
      block_left_q <= block_left_d;
      zero_pend_q  <= zero_pend_d;
      malform_q    <= malform_d;
      dec_cnt_q    <= dec_cnt_d;
      crc_q        <= crc_d;
      cmd_q        <= cmd_d;
      len_q        <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_OK;
      emit_q   <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.eval_en) begin
      status_q <= status_d;
      emit_q   <= (status_d == ST_OK) && (len_q != 8'd0);
      rd_idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      rd_idx_q <= rd_idx_q + AW'(1);
    end
  end

  ccd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_DATA),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(store_idx[AW-1:0]),
    .wdata_i(take_byte),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign stat_o.is_delim    = (byte_i == 8'd0);
  assign stat_o.frame_empty = (enc_cnt_q == 9'd0) && !ovf_q;
  assign stat_o.single      = !emit_q;
  assign stat_o.last_byte   = ((9'(rd_idx_q) + 9'd1) == {1'b0, len_q});

  assign data_byte_o    = emit_q ? ram_rdata : 8'd0;
  assign data_valid_o   = emit_q;
  assign status_o       = status_q;
  assign command_code_o = cmd_q;
  assign last_o         = emit_q ? stat_o.last_byte : 1'b1;

endmodule

### rtl/ccd_ctrl.sv
module ccd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ccd_pkg::ccd_stat_t stat_i,
  output ccd_pkg::ccd_cmd_t  cmd_o
);
  import ccd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_SEND   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_req;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SEND);
  assign in_req      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_req) begin
          if (!stat_i.is_delim) begin
            cmd_o.byte_en = 1'b1;
          end else if (stat_i.frame_empty) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.eval_en = 1'b1;
            state_d       = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        state_d = stat_i.single ? S_SEND : S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) begin
          if (stat_i.single || stat_i.last_byte) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/cobs_crc8_command_deframer.sv
// A non-zero encoded byte is taken on acceptance and the next request can follow at once.
// After a delimiter the status is registered in the decide state and offered in the send state;
// each data byte is read from the store in a read state and held in the send state until taken.
// Input is not taken while a frame's results are being delivered.
// Reset (async, active low) clears the frame state and sets the send opcode to 1;
// the payload store is not cleared.
module cobs_crc8_command_deframer #(
  parameter int unsigned MAX_ENCODED = ccd_pkg::DEF_MAX_ENCODED,
  parameter int unsigned MAX_DATA    = ccd_pkg::DEF_MAX_DATA
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  ccd_byte_if.sink            serial_i,
  ccd_result_if.source        result_o
);
  import ccd_pkg::*;

  ccd_cmd_t  cmd;
  ccd_stat_t stat;

  ccd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (serial_i.valid),
    .in_ready_o (serial_i.ready),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccd_datapath #(
    .MAX_ENCODED(MAX_ENCODED),
    .MAX_DATA   (MAX_DATA)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .byte_i        (serial_i.serial_byte),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .data_byte_o   (result_o.data_byte),
    .data_valid_o  (result_o.data_valid),
    .status_o      (result_o.status),
    .command_code_o(result_o.command_code),
    .last_o        (result_o.last)
  );

endmodule

### rtl/ccd_checker.sv
module ccd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] data_byte_i,
  input logic       data_valid_i,
  input logic [2:0] status_i,
  input logic       last_i
);
  import ccd_pkg::*;

  // A pending result stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(data_byte_i))
    else $error("data byte changed while stalled");

  // Payload bytes only come from frames that passed every check.
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && data_valid_i |-> status_i == ST_OK)
    else $error("payload byte with a fault status");

  // A status-only result always closes its frame.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !data_valid_i |-> last_i)
    else $error("status result without last");

  // Input is held off while results of a frame are delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken during frame delivery");

endmodule

bind cobs_crc8_command_deframer ccd_checker u_ccd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (serial_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .data_byte_i (result_o.data_byte),
  .data_valid_i(result_o.data_valid),
  .status_i    (result_o.status),
  .last_i      (result_o.last)
);

### tb/testbench.sv
typedef logic [7:0] byte_q_t[$];

typedef struct packed {
  logic [7:0] data_byte;
  logic       data_valid;
  logic [2:0] status;
  logic [7:0] command_code;
  logic       last;
} frame_result_t;

localparam int unsigned MAX_ENCODED = ccd_pkg::DEF_MAX_ENCODED;
localparam int unsigned MAX_DATA    = ccd_pkg::DEF_MAX_DATA;
localparam int unsigned STORE_DEPTH = MAX_DATA + 1;

// CRC-8 over one byte, MSB first, init and final value untouched.
function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
  logic [7:0] r;
  r = crc ^ b;
  repeat (8) begin
    r = r[7] ? ({r[6:0], 1'b0} ^ ccd_pkg::CRC_POLY) : {r[6:0], 1'b0};
  end
  return r;
endfunction

// Tracks the deframer state byte by byte and holds the results it must produce.
class frame_scoreboard;
  logic [7:0]    opcode;
  int unsigned   enc_cnt;
  int unsigned   dec_cnt;
  bit            ovf;
  bit            zpend;
  bit            malf;
  logic [7:0]    blk_left;
  logic [7:0]    crc;
  logic [7:0]    cmd_byte;
  logic [7:0]    len_byte;
  logic [7:0]    store [STORE_DEPTH];
  frame_result_t expected_q[$];
  int            errors;
  int            checked;
  int            predicted;
  int            taken;
  int            frames;
  logic [7:0]    status_seen;

  function new();
    opcode      = 8'h01;
    errors      = 0;
    checked     = 0;
    predicted   = 0;
    taken       = 0;
    frames      = 0;
    status_seen = '0;
    clear();
  endfunction

  function void clear();
    enc_cnt  = 0;
    dec_cnt  = 0;
    ovf      = 1'b0;
    zpend    = 1'b0;
    malf     = 1'b0;
    blk_left = '0;
    crc      = '0;
    cmd_byte = '0;
    len_byte = '0;
  endfunction

  function void take_decoded(logic [7:0] b);
    if (dec_cnt >= ccd_pkg::DEC_CNT_MAX) begin
      malf = 1'b1;
      return;
    end
    crc = crc8_next(crc, b);
    if (dec_cnt == 0) begin
      cmd_byte = b;
    end else if (dec_cnt == 1) begin
      len_byte = b;
    end else if (dec_cnt - 2 < STORE_DEPTH) begin
      store[dec_cnt - 2] = b;
    end
    dec_cnt++;
  endfunction

  function void push_result(logic [7:0] d, logic v, logic [2:0] s, logic [7:0] c, logic l);
    frame_result_t r;
    r.data_byte    = d;
    r.data_valid   = v;
    r.status       = s;
    r.command_code = c;
    r.last         = l;
    expected_q.push_back(r);
    predicted++;
  endfunction

  function void note_request(logic [7:0] b);
    logic [2:0] st;
    logic [7:0] cmd_out;
    if (b != 8'h00) begin
      if (ovf) return;
      if (enc_cnt >= MAX_ENCODED) begin
        ovf = 1'b1;
        return;
      end
      enc_cnt++;
      taken++;
      if (blk_left == 0) begin
        // A new code byte; a zero left pending by a short block is emitted now.
        if (zpend) take_decoded(8'h00);
        blk_left = b - 8'h01;
        zpend    = (b < ccd_pkg::BLOCK_FULL);
      end else begin
        take_decoded(b);
        blk_left--;
      end
      return;
    end
    taken++;
    if (enc_cnt == 0 && !ovf) begin
      clear();
      return;
    end
    cmd_out = (dec_cnt >= 1) ? cmd_byte : 8'h00;
    if (ovf) st = ccd_pkg::ST_OVERFLOW;
    else if (malf || blk_left != 0) st = ccd_pkg::ST_MALFORM;
    else if (dec_cnt < 3) st = ccd_pkg::ST_SHORT;
    else if (dec_cnt != int'(len_byte) + 3) st = ccd_pkg::ST_LEN;
    else if (crc != 8'h00) st = ccd_pkg::ST_CRC;
    else if (len_byte > MAX_DATA) st = ccd_pkg::ST_TOO_LONG;
    else if (cmd_byte != opcode) st = ccd_pkg::ST_OTHER;
    else st = ccd_pkg::ST_OK;
    frames++;
    status_seen[st] = 1'b1;
    if (st != ccd_pkg::ST_OK || len_byte == 0) begin
      push_result(8'h00, 1'b0, st, cmd_out, 1'b1);
    end else begin
      for (int i = 0; i < len_byte && i < STORE_DEPTH; i++) begin
        push_result(store[i], 1'b1, ccd_pkg::ST_OK, cmd_out, (i + 1 == len_byte));
      end
    end
    clear();
  endfunction

  function void match(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(frame_result_t got);
    frame_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: data 0x%0h status %0d", got.data_byte, got.status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    match("data_byte", want.data_byte, got.data_byte);
    match("data_valid", 8'(want.data_valid), 8'(got.data_valid));
    match("status", 8'(want.status), 8'(got.status));
    match("command_code", want.command_code, got.command_code);
    match("last", 8'(want.last), 8'(got.last));
  endfunction
endclass

function automatic logic [7:0] random_data(int fill);
  if (fill >= 0) return 8'(fill);
  case ($urandom_range(0, 3))
    0:       return 8'h00;
    1:       return 8'hFF;
    default: return 8'($urandom_range(0, 255));
  endcase
endfunction

// Decoded body: command, length, data, then a CRC that zeroes the check (corrupted if bad_crc).
function automatic byte_q_t make_body(logic [7:0] cmd, logic [7:0] len_field, int n_data,
                                      bit bad_crc, int fill);
  byte_q_t body;
  logic [7:0] c;
  body.push_back(cmd);
  body.push_back(len_field);
  repeat (n_data) body.push_back(random_data(fill));
  c = 8'h00;
  foreach (body[i]) c = crc8_next(c, body[i]);
  if (bad_crc) c = c ^ 8'($urandom_range(1, 255));
  body.push_back(c);
  return body;
endfunction

function automatic byte_q_t cobs_encode(byte_q_t body);
  byte_q_t enc;
  int code_pos;
  int run;
  enc.push_back(8'h00);
  code_pos = 0;
  run      = 0;
  foreach (body[i]) begin
    if (body[i] == 8'h00) begin
      enc[code_pos] = 8'(run + 1);
      enc.push_back(8'h00);
      code_pos = enc.size() - 1;
      run      = 0;
    end else begin
      enc.push_back(body[i]);
      run++;
      if (run == 254) begin
        enc[code_pos] = ccd_pkg::BLOCK_FULL;
        enc.push_back(8'h00);
        code_pos = enc.size() - 1;
        run      = 0;
      end
    end
  end
  enc[code_pos] = 8'(run + 1);
  return enc;
endfunction

function automatic byte_q_t noise(int n, bit nonzero);
  byte_q_t q;
  repeat (n) q.push_back(8'($urandom_range(nonzero ? 1 : 0, 255)));
  return q;
endfunction

module testbench;
  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  bit         fast_tx;
  bit         fast_rx;

  ccd_byte_if   byte_bus ();
  ccd_result_if res_bus ();

  frame_scoreboard sb;

  cobs_crc8_command_deframer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .serial_i    (byte_bus),
    .result_o    (res_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Valid stays high between back-to-back requests and is only dropped for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.serial_byte <= b;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    sb.note_request(b);
  endtask

  task automatic send_raw(input byte_q_t enc);
    foreach (enc[i]) send_byte(enc[i]);
    send_byte(8'h00);
  endtask

  task automatic send_body(input byte_q_t body);
    send_raw(cobs_encode(body));
  endtask

  // Holds the sender off until the block has delivered everything and settled.
  task automatic quiesce();
    byte_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_opcode(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.opcode = value;
  endtask

  initial begin : result_sink
    int stall;
    frame_result_t got;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = fast_rx ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_bus.valid) @(posedge clk_i);
      got.data_byte    = res_bus.data_byte;
      got.data_valid   = res_bus.data_valid;
      got.status       = res_bus.status;
      got.command_code = res_bus.command_code;
      got.last         = res_bus.last;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    byte_q_t q;
    int kind;
    int n;
    int len;
    int frame_no;
    int t0;
    int p0;
    sb = new();
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= 8'h00;
    byte_bus.valid       <= 1'b0;
    byte_bus.serial_byte <= 8'h00;
    fast_tx = 1'b0;
    fast_rx = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset opcode.
    send_byte(8'h00);
    send_body(make_body(8'h01, 8'd0, 0, 1'b0, -1));
    send_body(make_body(8'h01, 8'd1, 1, 1'b0, 8'h00));
    send_body(make_body(8'h01, 8'd64, 64, 1'b0, 8'hFF));
    send_body(make_body(8'h01, 8'd3, 3, 1'b0, 8'h00));
    q = {8'h01};
    send_raw(q);
    q = {8'h02, 8'h01};
    send_raw(q);
    q = {8'h03, 8'h01, 8'h05};
    send_raw(q);
    send_body(make_body(8'h01, 8'd5, 3, 1'b0, -1));
    send_body(make_body(8'h01, 8'd2, 2, 1'b1, -1));
    send_body(make_body(8'h01, 8'd65, 65, 1'b0, -1));
    send_body(make_body(8'h02, 8'd2, 2, 1'b0, -1));
    // Block left open at the delimiter.
    q = cobs_encode(make_body(8'h01, 8'd2, 2, 1'b0, -1));
    q.push_back(8'h04);
    q.push_back(8'h11);
    send_raw(q);
    send_raw(noise(MAX_ENCODED + 1, 1'b1));
    send_body(make_body(8'h01, 8'd4, 4, 1'b0, -1));
    send_byte(8'h00);
    send_raw(noise(10, 1'b0));

    quiesce();
    set_opcode(8'h00);
    send_body(make_body(8'h00, 8'd3, 3, 1'b0, -1));
    send_body(make_body(8'h01, 8'd3, 3, 1'b0, -1));
    quiesce();
    set_opcode(8'hFF);
    send_body(make_body(8'hFF, 8'd2, 2, 1'b0, -1));
    send_body(make_body(8'h00, 8'd2, 2, 1'b0, -1));

    // Random frames, well formed and faulty, with the opcode changed now and then.
    t0 = sb.taken;
    p0 = sb.predicted;
    frame_no = 0;
    while (sb.taken - t0 < 160 || sb.predicted - p0 < 48) begin
      if (frame_no % 8 == 0) begin
        quiesce();
        case ($urandom_range(0, 3))
          0:       set_opcode(8'h00);
          1:       set_opcode(8'hFF);
          default: set_opcode(8'($urandom_range(0, 255)));
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        quiesce();
      end
      fast_tx = ($urandom_range(0, 4) == 0);
      fast_rx = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_DATA) : $urandom_range(0, 6);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_body(make_body(sb.opcode, 8'(len), len, 1'b0, -1));
      end else if (kind < 55) begin
        send_body(make_body(sb.opcode ^ 8'($urandom_range(1, 255)), 8'(len), len, 1'b0, -1));
      end else if (kind < 63) begin
        send_body(make_body(sb.opcode, 8'(len), len, 1'b1, -1));
      end else if (kind < 70) begin
        n = (len > 0 && $urandom_range(0, 1) == 0) ? len - 1 : len + $urandom_range(1, 3);
        send_body(make_body(sb.opcode, 8'(len), n, 1'b0, -1));
      end else if (kind < 75) begin
        len = $urandom_range(MAX_DATA + 1, MAX_DATA + 8);
        send_body(make_body(8'($urandom_range(0, 255)), 8'(len), len, 1'b0, -1));
      end else if (kind < 80) begin
        send_body(noise($urandom_range(0, 2), 1'b0));
      end else if (kind < 86) begin
        q = cobs_encode(make_body(sb.opcode, 8'(len), len, 1'b0, -1));
        n = $urandom_range(2, 20);
        q.push_back(8'(n));
        repeat ($urandom_range(0, n - 2)) q.push_back(8'($urandom_range(1, 255)));
        send_raw(q);
      end else if (kind < 90) begin
        send_byte(8'h00);
      end else begin
        send_raw(noise($urandom_range(1, 12), 1'b0));
      end
      frame_no++;
    end

    fast_tx = 1'b0;
    fast_rx = 1'b0;
    byte_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d frames from %0d accepted bytes, %0d results checked",
             sb.frames, sb.taken, sb.checked);
    $display("Status codes reached (one bit per code, MSB = too long): %08b", sb.status_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
